FILE: rtl/core/clr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_pkg: shared types and constants for the line rasterizer
// Opcode type, register indexes, register reset values and fixed field widths.
// ----------------------------------------------------------------------------
package clr_pkg;

  // Fixed field widths
  localparam int FRAME_DIM_W = 13;
  localparam int COLOR_W     = 32;
  localparam int ADDR_W      = 24;
  localparam int CFG_IDX_W   = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd960;
  localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd540;

  // Input beat opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

endpackage

FILE: rtl/core/clr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_in_if: command channel of the line rasterizer
// Valid/ready channel carrying a load or step command.
// ----------------------------------------------------------------------------
interface clr_in_if #(
  parameter int COORD_BITS = 13
);
  import clr_pkg::*;

  logic                         valid;
  logic                         ready;
  opcode_t                      opcode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOR_W-1:0]           draw_color;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, draw_color,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, draw_color,
    output ready
  );
endinterface

FILE: rtl/core/clr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_out_if: pixel channel of the line rasterizer
// Valid/ready channel carrying one generated pixel per beat.
// ----------------------------------------------------------------------------
interface clr_out_if #(
  parameter int COORD_BITS = 13
);
  import clr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_W-1:0]           pixel_color;
  logic                         in_frame;
  logic [ADDR_W-1:0]            pixel_address;
  logic                         last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, in_frame, pixel_address, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, in_frame, pixel_address, last,
    output ready
  );
endinterface

FILE: rtl/core/clr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_cfg_if: register write channel of the line rasterizer
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface clr_cfg_if;
  import clr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [FRAME_DIM_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/clipped_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer: Bresenham line engine with frame clipping
// Walks a line one pixel per step command, flags off-frame pixels and
// computes the linear frame address of on-frame ones.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : commands. A load beat latches endpoints and color and makes no
//            pixel. A step beat makes one pixel while a line is active and
//            nothing otherwise. A load mid-line replaces the current line.
//   out_ch : pixels. last marks the endpoint; the line is then finished.
//   cfg_ch : frame_width (index 0) and frame_height (index 1). Always ready;
//            write only while the engine is idle.
// Timing:
//   One beat per clock is accepted while in_ch.ready is high. A pixel appears
//   on out_ch the cycle after its step beat. The Bresenham update (adds and
//   compares on the error term) is combinational into the cursor registers,
//   and the address multiply-add is combinational into the output register.
//   in_ch.ready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds the pixel and blocks new commands.
// Reset (rst_n low, synchronous): no line active, output empty, frame size
// back to 960 x 540.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer #(
  parameter int COORD_BITS = 13
) (
  input  logic      clk,
  input  logic      rst_n,
  clr_in_if.sink    in_ch,
  clr_out_if.source out_ch,
  clr_cfg_if.sink   cfg_ch
);
  import clr_pkg::*;

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 3;
  localparam int CMP_W  = (COORD_BITS > FRAME_DIM_W) ? COORD_BITS : FRAME_DIM_W;

  // Configuration registers
  logic [FRAME_DIM_W-1:0] frame_w_r;
  logic [FRAME_DIM_W-1:0] frame_h_r;

  // Line state
  logic                         active_r;
  logic signed [COORD_BITS-1:0] cursor_x_r, cursor_y_r;
  logic signed [COORD_BITS-1:0] target_x_r, target_y_r;
  logic signed [SPAN_W-1:0]     span_x_r, neg_span_y_r;
  logic                         step_x_neg_r, step_y_neg_r;
  logic signed [ERR_W-1:0]      error_r;
  logic [COLOR_W-1:0]           color_r;

  // Output register
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [COLOR_W-1:0]           out_color_r;
  logic                         out_in_frame_r;
  logic [ADDR_W-1:0]            out_addr_r;
  logic                         out_last_r;

  // Handshake
  logic in_acc, load_acc, step_acc, pixel_acc;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign load_acc  = in_acc && (in_ch.opcode == OP_LOAD);
  assign step_acc  = in_acc && (in_ch.opcode == OP_STEP);
  assign pixel_acc = step_acc && active_r;

  // Load setup: spans, step directions, initial error
  logic signed [SPAN_W-1:0] dx, dy, span_x_nxt, neg_span_y_nxt;
  logic signed [ERR_W-1:0]  error_load;

  assign dx = SPAN_W'(in_ch.end_x) - SPAN_W'(in_ch.start_x);
  assign dy = SPAN_W'(in_ch.end_y) - SPAN_W'(in_ch.start_y);
  assign span_x_nxt     = dx[SPAN_W-1] ? -dx : dx;
  assign neg_span_y_nxt = dy[SPAN_W-1] ? dy : -dy;
  assign error_load     = ERR_W'(span_x_nxt) + ERR_W'(neg_span_y_nxt);

  // Current pixel: clip test, address, endpoint check
  logic              on_frame, done;
  logic [ADDR_W-1:0] addr_nxt;

  assign on_frame = !cursor_x_r[COORD_BITS-1] && !cursor_y_r[COORD_BITS-1] &&
                    (CMP_W'($unsigned(cursor_x_r)) < CMP_W'(frame_w_r)) &&
                    (CMP_W'($unsigned(cursor_y_r)) < CMP_W'(frame_h_r));
  assign done   = (cursor_x_r == target_x_r) && (cursor_y_r == target_y_r);
  assign addr_nxt = on_frame ?
      (ADDR_W'($unsigned(cursor_y_r)) * ADDR_W'(frame_w_r) +
       ADDR_W'($unsigned(cursor_x_r))) : '0;

  // Bresenham advance
  logic signed [ERR_W-1:0]      e2, nsy_ext, sx_ext, error_nxt;
  logic                         move_x, move_y;
  logic signed [COORD_BITS-1:0] cursor_x_nxt, cursor_y_nxt;

  assign e2      = error_r <<< 1;
  assign nsy_ext = ERR_W'(neg_span_y_r);
  assign sx_ext  = ERR_W'(span_x_r);
  assign move_x  = e2 >= nsy_ext;
  assign move_y  = e2 <= sx_ext;
  assign error_nxt = error_r + (move_x ? nsy_ext : '0) + (move_y ? sx_ext : '0);
  assign cursor_x_nxt = !move_x ? cursor_x_r :
                        step_x_neg_r ? cursor_x_r - COORD_BITS'(1)
                                     : cursor_x_r + COORD_BITS'(1);
  assign cursor_y_nxt = !move_y ? cursor_y_r :
                        step_y_neg_r ? cursor_y_r - COORD_BITS'(1)
                                     : cursor_y_r + COORD_BITS'(1);

  // Control state: config registers, line active, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r   <= FRAME_WIDTH_RST;
      frame_h_r   <= FRAME_HEIGHT_RST;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_FRAME_WIDTH:  frame_w_r <= cfg_ch.data;
          REG_FRAME_HEIGHT: frame_h_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (load_acc) begin
        active_r <= 1'b1;
      end else if (pixel_acc && done) begin
        active_r <= 1'b0;
      end
      if (pixel_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load_acc) begin
      cursor_x_r   <= in_ch.start_x;
      cursor_y_r   <= in_ch.start_y;
      target_x_r   <= in_ch.end_x;
      target_y_r   <= in_ch.end_y;
      span_x_r     <= span_x_nxt;
      neg_span_y_r <= neg_span_y_nxt;
      step_x_neg_r <= !(in_ch.start_x < in_ch.end_x);
      step_y_neg_r <= !(in_ch.start_y < in_ch.end_y);
      error_r      <= error_load;
      color_r      <= in_ch.draw_color;
    end else if (pixel_acc && !done) begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      error_r    <= error_nxt;
    end
    if (pixel_acc) begin
      out_x_r        <= cursor_x_r;
      out_y_r        <= cursor_y_r;
      out_color_r    <= color_r;
      out_in_frame_r <= on_frame;
      out_addr_r     <= addr_nxt;
      out_last_r     <= done;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_x       = out_x_r;
  assign out_ch.pixel_y       = out_y_r;
  assign out_ch.pixel_color   = out_color_r;
  assign out_ch.in_frame      = out_in_frame_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.last          = out_last_r;

  // Checks
  a_load_sets_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> active_r && (cursor_x_r == $past(in_ch.start_x)) &&
                 (cursor_y_r == $past(in_ch.start_y)))
    else $error("load did not latch the start point");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step_acc && !active_r && !out_valid_r) |=> !out_valid_r)
    else $error("step with no active line produced a pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (pixel_acc && done) |=> !active_r && out_valid_r && out_last_r)
    else $error("endpoint pixel did not end the line");

  a_clipped_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_frame_r) |-> (out_addr_r == '0))
    else $error("clipped pixel carries a nonzero address");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_acc)
    else $error("command accepted while a pixel is stalled");

endmodule
